/* rtl/rle4_pkg.sv */
// ----------------------------------------------------------------------------
// rle4_pkg
// shared types and constants of the rle4 pixel run encoder
// ----------------------------------------------------------------------------
package rle4_pkg;

  localparam int PIX_W  = 4;
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 16;
  localparam int ADDR_W = 1;

  localparam logic [BYTE_W-1:0] MAX_RUN = 8'd255;
  localparam logic [BYTE_W-1:0] ESC_PAIR = 8'h00;
  localparam logic [BYTE_W-1:0] ESC_EOL  = 8'h00;
  localparam logic [BYTE_W-1:0] ESC_EOB  = 8'h01;

  localparam logic [ADDR_W-1:0] REG_ROW_WIDTH = 1'd0;
  localparam logic [ADDR_W-1:0] REG_ROW_TOTAL = 1'd1;

  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_PW    = $clog2(EVQ_DEPTH);
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_PW     = $clog2(OQ_DEPTH);

  // position of a pair inside the row-end group
  localparam logic [1:0] J_CLOSE = 2'd0;
  localparam logic [1:0] J_EOL   = 2'd1;
  localparam logic [1:0] J_EOB   = 2'd2;

  // work for the back end, one per pixel that causes pairs
  typedef struct packed {
    logic              has_flush;
    logic [BYTE_W-1:0] flush_len;
    logic [PIX_W-1:0]  flush_color;
    logic              has_close;
    logic [BYTE_W-1:0] close_len;
    logic [PIX_W-1:0]  close_color;
    logic              eob;
  } evt_t;

endpackage

/* rtl/rle4_front.sv */
// ----------------------------------------------------------------------------
// rle4_front
// takes pixels, tracks run, column and row, and classifies each pixel
// ----------------------------------------------------------------------------
module rle4_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rle4_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [rle4_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        take,
  input  logic [rle4_pkg::PIX_W-1:0]  pixel,
  output logic                        evt_valid,
  output rle4_pkg::evt_t              evt
);

  logic [rle4_pkg::CFG_W-1:0]  row_width_r, row_total_r;
  logic [rle4_pkg::PIX_W-1:0]  color_r, color_nxt;
  logic [rle4_pkg::BYTE_W-1:0] len_r, len_nxt, len_upd;
  logic [rle4_pkg::CFG_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [rle4_pkg::CFG_W-1:0]  w_eff, t_eff;
  logic [rle4_pkg::CFG_W:0]    col_inc, row_inc;
  logic                        flush, eor, eob;

  always_comb begin
    w_eff   = (row_width_r == '0) ? rle4_pkg::CFG_W'(1) : row_width_r;
    t_eff   = (row_total_r == '0) ? rle4_pkg::CFG_W'(1) : row_total_r;
    flush   = (len_r != '0) && ((pixel != color_r) || (len_r >= rle4_pkg::MAX_RUN));
    if (flush || len_r == '0) begin
      len_upd   = rle4_pkg::BYTE_W'(1);
      color_nxt = pixel;
    end else begin
      len_upd   = len_r + rle4_pkg::BYTE_W'(1);
      color_nxt = color_r;
    end
    col_inc = {1'b0, col_r} + (rle4_pkg::CFG_W+1)'(1);
    row_inc = {1'b0, row_r} + (rle4_pkg::CFG_W+1)'(1);
    eor     = col_inc >= {1'b0, w_eff};
    eob     = eor && (row_inc >= {1'b0, t_eff});
    len_nxt = eor ? '0 : len_upd;
    col_nxt = eor ? '0 : col_inc[rle4_pkg::CFG_W-1:0];
    if (!eor) begin
      row_nxt = row_r;
    end else if (eob) begin
      row_nxt = '0;
    end else begin
      row_nxt = row_inc[rle4_pkg::CFG_W-1:0];
    end

    evt.has_flush   = flush;
    evt.flush_len   = len_r;
    evt.flush_color = color_r;
    evt.has_close   = eor;
    evt.close_len   = len_upd;
    evt.close_color = color_nxt;
    evt.eob         = eob;
    evt_valid       = take && (flush || eor);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= rle4_pkg::CFG_W'(1);
      row_total_r <= rle4_pkg::CFG_W'(1);
      color_r     <= '0;
      len_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          rle4_pkg::REG_ROW_WIDTH: row_width_r <= cfg_wdata;
          rle4_pkg::REG_ROW_TOTAL: row_total_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (take) begin
        color_r <= color_nxt;
        len_r   <= len_nxt;
        col_r   <= col_nxt;
        row_r   <= row_nxt;
      end
    end
  end

endmodule

/* rtl/rle4_evq.sv */
// ----------------------------------------------------------------------------
// rle4_evq
// short queue of classified pixels between front and back
// ----------------------------------------------------------------------------
module rle4_evq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic           pop,
  input  rle4_pkg::evt_t wr_data,
  output rle4_pkg::evt_t rd_data,
  output logic           full,
  output logic           empty
);

  rle4_pkg::evt_t                mem [rle4_pkg::EVQ_DEPTH];
  logic [rle4_pkg::EVQ_PW-1:0]   wptr_r, rptr_r;
  logic [rle4_pkg::EVQ_PW:0]     cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  always_comb begin
    full    = cnt_r == (rle4_pkg::EVQ_PW+1)'(rle4_pkg::EVQ_DEPTH);
    empty   = cnt_r == '0;
    do_push = push && !full;
    do_pop  = pop && !empty;
    cnt_nxt = cnt_r + (rle4_pkg::EVQ_PW+1)'(do_push) - (rle4_pkg::EVQ_PW+1)'(do_pop);
    rd_data = mem[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + rle4_pkg::EVQ_PW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + rle4_pkg::EVQ_PW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/rle4_back.sv */
// ----------------------------------------------------------------------------
// rle4_back
// expands each queued entry into byte pairs, one per cycle while the output queue has room
// ----------------------------------------------------------------------------
module rle4_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        evt_avail,
  input  rle4_pkg::evt_t              evt,
  output logic                        evt_done,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [rle4_pkg::BYTE_W-1:0] out_first_byte,
  output logic [rle4_pkg::BYTE_W-1:0] out_second_byte,
  output logic                        out_last
);

  logic [1:0]                  step_r;
  logic [1:0]                  j;
  logic [2:0]                  n_pairs;
  logic                        emit, is_last;
  logic [rle4_pkg::BYTE_W-1:0] a_byte, b_byte;

  logic [rle4_pkg::BYTE_W-1:0] fb_mem [rle4_pkg::OQ_DEPTH];
  logic [rle4_pkg::BYTE_W-1:0] sb_mem [rle4_pkg::OQ_DEPTH];
  logic                        lb_mem [rle4_pkg::OQ_DEPTH];
  logic [rle4_pkg::OQ_PW-1:0]  wptr_r, rptr_r;
  logic [rle4_pkg::OQ_PW:0]    cnt_r;
  logic                        oq_full, do_pop;

  always_comb begin
    n_pairs = 3'(evt.has_flush) + (evt.has_close ? (3'd2 + 3'(evt.eob)) : 3'd0);
    is_last = {1'b0, step_r} == (n_pairs - 3'd1);
    j       = step_r - 2'(evt.has_flush);
    if (evt.has_flush && step_r == 2'd0) begin
      a_byte = evt.flush_len;
      b_byte = {evt.flush_color, evt.flush_color};
    end else begin
      case (j)
        rle4_pkg::J_CLOSE: begin
          a_byte = evt.close_len;
          b_byte = {evt.close_color, evt.close_color};
        end
        rle4_pkg::J_EOL: begin
          a_byte = rle4_pkg::ESC_PAIR;
          b_byte = rle4_pkg::ESC_EOL;
        end
        default: begin
          a_byte = rle4_pkg::ESC_PAIR;
          b_byte = rle4_pkg::ESC_EOB;
        end
      endcase
    end
    oq_full   = cnt_r == (rle4_pkg::OQ_PW+1)'(rle4_pkg::OQ_DEPTH);
    out_empty = cnt_r == '0;
    do_pop    = out_pop && !out_empty;
    emit      = evt_avail && !oq_full;
    evt_done  = emit && is_last;
    out_first_byte  = fb_mem[rptr_r];
    out_second_byte = sb_mem[rptr_r];
    out_last        = lb_mem[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      fb_mem[wptr_r] <= a_byte;
      sb_mem[wptr_r] <= b_byte;
      lb_mem[wptr_r] <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (emit) begin
        step_r <= is_last ? 2'd0 : step_r + 2'd1;
        wptr_r <= wptr_r + rle4_pkg::OQ_PW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + rle4_pkg::OQ_PW'(1);
      end
      cnt_r <= cnt_r + (rle4_pkg::OQ_PW+1)'(emit) - (rle4_pkg::OQ_PW+1)'(do_pop);
    end
  end

endmodule

/* rtl/rle4_pixel_run_encoder.sv */
// path: a run-closing pixel is queued as an event, its pairs in the output queue
// throughput: one pixel per cycle; the back end writes one pair per cycle while
//   the output queue has room, so a row end (up to four pairs) holds the input
//   only once the 4-entry event queue fills
// reset: synchronous active-low rst_n clears run, column and row counts and both
//   queues; row_width and row_total return to 1
// ----------------------------------------------------------------------------
// rle4_pixel_run_encoder
// bitmap rle4 encoded-mode run encoder, front classifier and back pair writer
// ----------------------------------------------------------------------------
module rle4_pixel_run_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rle4_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [rle4_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [rle4_pkg::PIX_W-1:0]  in_pixel,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [rle4_pkg::BYTE_W-1:0] out_first_byte,
  output logic [rle4_pkg::BYTE_W-1:0] out_second_byte,
  output logic                        out_last
);

  rle4_pkg::evt_t evt_in, evt_out;
  logic           take, evt_valid, evt_done, q_full, q_empty;

  assign in_full = q_full;
  assign take    = in_push && !q_full;

  rle4_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .pixel     (in_pixel),
    .evt_valid (evt_valid),
    .evt       (evt_in)
  );

  rle4_evq u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (evt_valid),
    .pop     (evt_done),
    .wr_data (evt_in),
    .rd_data (evt_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  rle4_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .evt_avail       (!q_empty),
    .evt             (evt_out),
    .evt_done        (evt_done),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_first_byte  (out_first_byte),
    .out_second_byte (out_second_byte),
    .out_last        (out_last)
  );

endmodule
